// ===== src/dsniff_pkg.sv =====
package dsniff_pkg;

  // Counter width for the per-line delimiter counts
  localparam int unsigned COUNT_WIDTH = 16;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [1:0]             status_t;
  typedef logic [1:0]             delim_t;
  typedef logic [7:0]             byte_t;

  // Input operation codes
  localparam logic OP_DATA = 1'b0;
  localparam logic OP_END  = 1'b1;

  // Reference status codes (code three is never written, reads as bad)
  localparam status_t ST_UNSET = 2'd0;
  localparam status_t ST_SET   = 2'd1;
  localparam status_t ST_BAD   = 2'd2;

  // Delimiter codes, also the index into the count arrays
  localparam delim_t DELIM_COMMA = 2'd0;
  localparam delim_t DELIM_TAB   = 2'd1;
  localparam delim_t DELIM_SEMI  = 2'd2;
  localparam int unsigned NUM_DELIMS = 3;

  // Characters of interest
  localparam byte_t CH_QUOTE = 8'h22;
  localparam byte_t CH_LF    = 8'h0A;
  localparam byte_t CH_CR    = 8'h0D;
  localparam byte_t CH_COMMA = 8'h2C;
  localparam byte_t CH_TAB   = 8'h09;
  localparam byte_t CH_SEMI  = 8'h3B;

endpackage

// ===== src/delimiter_sniffer.sv =====
// Delimiter sniffer: feed a text buffer as data beats (op = 0, one byte per
// beat) and close it with an end beat (op = 1). The end beat yields one
// result beat naming the delimiter: 0 comma, 1 tab, 2 semicolon, chosen in
// that order as the first whose per-line count is non-zero and equal on
// every line with content; comma when none qualifies. All tracking state
// clears after each end beat, so the next buffer may follow at once.
// The block accepts one beat per cycle except while an end beat is held
// back; the result passes through the input register and then the state
// update into the output register. The only back-pressure comes from an
// end beat waiting while the previous result is still held in the output
// register; a data beat never causes that wait itself.
module delimiter_sniffer (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                op,
  input  dsniff_pkg::byte_t   data_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output dsniff_pkg::delim_t  delimiter
);
  import dsniff_pkg::*;

  // Input register
  logic  s1_valid;
  logic  s1_op;
  byte_t s1_byte;

  // Sniffer state
  logic    in_quotes;
  logic    line_has_content;
  count_t  line_counts      [NUM_DELIMS];
  count_t  reference_counts [NUM_DELIMS];
  status_t reference_status [NUM_DELIMS];

  logic    in_quotes_next;
  logic    line_has_content_next;
  count_t  line_counts_next      [NUM_DELIMS];
  count_t  reference_counts_next [NUM_DELIMS];
  status_t reference_status_next [NUM_DELIMS];

  logic    hold;
  logic    fire;
  logic    is_quote;
  logic    is_lf;
  logic    is_cr;
  logic    end_line;
  logic    bump [NUM_DELIMS];
  count_t  ref_line  [NUM_DELIMS];
  status_t stat_line [NUM_DELIMS];
  delim_t  choice;

  // An end beat waits while the previous result is unclaimed
  assign hold     = (s1_op == OP_END) && out_valid && out_stall;
  assign fire     = s1_valid && !hold;
  assign in_stall = s1_valid && hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
    if (!in_stall) begin
      s1_op   <= op;
      s1_byte <= data_byte;
    end
  end

  // Byte classification
  assign is_quote = (s1_op == OP_DATA) && (s1_byte == CH_QUOTE);
  assign is_lf    = (s1_op == OP_END) || (s1_byte == CH_LF);
  assign is_cr    = (s1_op == OP_DATA) && (s1_byte == CH_CR);

  // A line closes on a newline (real or virtual) outside quotes
  assign end_line = !is_quote && !in_quotes && is_lf && line_has_content;

  assign bump[DELIM_COMMA] = s1_byte == CH_COMMA;
  assign bump[DELIM_TAB]   = s1_byte == CH_TAB;
  assign bump[DELIM_SEMI]  = s1_byte == CH_SEMI;

  // Reference update at the close of a line
  always_comb begin
    for (int k = 0; k < NUM_DELIMS; k++) begin
      ref_line[k]  = reference_counts[k];
      stat_line[k] = reference_status[k];
      if (end_line) begin
        if (reference_status[k] == ST_UNSET) begin
          ref_line[k]  = line_counts[k];
          stat_line[k] = ST_SET;
        end else if (reference_counts[k] != line_counts[k]) begin
          stat_line[k] = ST_BAD;
        end
      end
    end
  end

  // Decision: first consistent, non-zero delimiter, else comma
  always_comb begin
    choice = DELIM_COMMA;
    for (int k = NUM_DELIMS - 1; k >= 0; k--) begin
      if (stat_line[k] == ST_SET && ref_line[k] != '0) begin
        choice = 2'(k);
      end
    end
  end

  // Next state
  always_comb begin
    in_quotes_next        = in_quotes;
    line_has_content_next = line_has_content;
    for (int k = 0; k < NUM_DELIMS; k++) begin
      line_counts_next[k]      = line_counts[k];
      reference_counts_next[k] = ref_line[k];
      reference_status_next[k] = stat_line[k];
    end
    if (s1_op == OP_END) begin
      in_quotes_next        = 1'b0;
      line_has_content_next = 1'b0;
      for (int k = 0; k < NUM_DELIMS; k++) begin
        line_counts_next[k]      = '0;
        reference_counts_next[k] = '0;
        reference_status_next[k] = ST_UNSET;
      end
    end else if (is_quote) begin
      in_quotes_next = !in_quotes;
    end else if (!in_quotes) begin
      if (is_lf) begin
        if (end_line) begin
          line_has_content_next = 1'b0;
          for (int k = 0; k < NUM_DELIMS; k++) begin
            line_counts_next[k] = '0;
          end
        end
      end else begin
        if (!is_cr) begin
          line_has_content_next = 1'b1;
        end
        // saturating count
        for (int k = 0; k < NUM_DELIMS; k++) begin
          if (bump[k] && !(&line_counts[k])) begin
            line_counts_next[k] = line_counts[k] + count_t'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_quotes        <= 1'b0;
      line_has_content <= 1'b0;
      for (int k = 0; k < NUM_DELIMS; k++) begin
        line_counts[k]      <= '0;
        reference_counts[k] <= '0;
        reference_status[k] <= ST_UNSET;
      end
    end else if (fire) begin
      in_quotes        <= in_quotes_next;
      line_has_content <= line_has_content_next;
      for (int k = 0; k < NUM_DELIMS; k++) begin
        line_counts[k]      <= line_counts_next[k];
        reference_counts[k] <= reference_counts_next[k];
        reference_status[k] <= reference_status_next[k];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && s1_op == OP_END) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (fire && s1_op == OP_END) begin
      delimiter <= choice;
    end
  end

endmodule
